// ----- src/assert_macros.svh -----
// assertion macros shared by the solver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define QRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition must never be seen at a clock edge out of reset
`define QRS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- src/qrs_pkg.sv -----
// shared types and constants of the quadratic root solver
`default_nettype none

package qrs_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOROOT = 2'd1,
        ST_AZERO  = 2'd2
    } t_status;

    // classification that travels with each item
    typedef struct packed {
        logic    a_neg;
        logic    b_pos;
        logic    c_neg;
        t_status status;
    } t_cls;

    // queue between front and back
    localparam int QDEPTH = 8;
    localparam int QAW    = 3;
    localparam int QCW    = 4;

endpackage

`default_nettype wire

// ----- src/qrs_front.sv -----
// front end: takes items, forms magnitudes, products and the discriminant
`default_nettype none
`include "assert_macros.svh"

module qrs_front
    import qrs_pkg::*;
#(
    parameter int W = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic signed [W-1:0]  i_coef_a,
    input  wire logic signed [W-1:0]  i_coef_b,
    input  wire logic signed [W-1:0]  i_coef_c,
    input  wire logic [QCW-1:0]       i_level,
    output logic                      o_push,
    output logic [W-1:0]              o_ma,
    output logic [W-1:0]              o_mb,
    output logic [W-1:0]              o_mc,
    output logic [2*W+1:0]            o_disc,
    output t_cls                      o_cls
);

    localparam int DW = 2 * W + 2;

    logic            w_accept;
    logic            w_a_neg, w_b_neg, w_c_neg;
    logic [W-1:0]    w_ma, w_mb, w_mc;
    logic [QCW:0]    w_load;

    logic            r_v1, r_v2, r_v3;
    logic [W-1:0]    r_ma1, r_mb1, r_mc1, r_ma2, r_mb2, r_mc2;
    t_cls            r_cls1, r_cls2, r_cls3;
    logic [2*W-1:0]  r_bb, r_ac;
    logic [W-1:0]    r_ma3, r_mb3, r_mc3;
    logic [DW-1:0]   r_disc;

    logic [DW-1:0]   w_ac4, w_bbx, w_sum;
    logic [DW:0]     w_diff;
    logic            w_add;
    t_cls            n_cls3;
    logic [DW-1:0]   n_disc;

    // hold off when the queue could not take every item in flight
    assign w_load   = {1'b0, i_level} + (QCW+1)'(r_v1) + (QCW+1)'(r_v2) + (QCW+1)'(r_v3);
    assign o_busy   = w_load >= (QCW+1)'(QDEPTH);
    assign w_accept = i_start && !o_busy;

    // magnitudes and signs
    assign w_a_neg = i_coef_a[W-1];
    assign w_b_neg = i_coef_b[W-1];
    assign w_c_neg = i_coef_c[W-1];
    assign w_ma    = w_a_neg ? (~i_coef_a + 1'b1) : i_coef_a;
    assign w_mb    = w_b_neg ? (~i_coef_b + 1'b1) : i_coef_b;
    assign w_mc    = w_c_neg ? (~i_coef_c + 1'b1) : i_coef_c;

    // discriminant from registered products
    assign w_ac4  = {r_ac, 2'b00};
    assign w_bbx  = {2'b00, r_bb};
    assign w_sum  = w_bbx + w_ac4;
    assign w_diff = {1'b0, w_bbx} - {1'b0, w_ac4};
    assign w_add  = (r_cls2.a_neg != r_cls2.c_neg) && (r_mc2 != '0);

    always_comb begin
        n_cls3 = r_cls2;
        n_disc = w_add ? w_sum : w_diff[DW-1:0];
        if (r_cls2.status == ST_OK && !w_add && w_diff[DW]) begin
            n_cls3.status = ST_NOROOT;
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_ma1        <= w_ma;
        r_mb1        <= w_mb;
        r_mc1        <= w_mc;
        r_cls1.a_neg <= w_a_neg;
        r_cls1.b_pos <= !w_b_neg && (i_coef_b != '0);
        r_cls1.c_neg <= w_c_neg;
        r_cls1.status <= (i_coef_a == '0) ? ST_AZERO : ST_OK;
        r_bb         <= r_mb1 * r_mb1;
        r_ac         <= r_ma1 * r_mc1;
        r_ma2        <= r_ma1;
        r_mb2        <= r_mb1;
        r_mc2        <= r_mc1;
        r_cls2       <= r_cls1;
        r_ma3        <= r_ma2;
        r_mb3        <= r_mb2;
        r_mc3        <= r_mc2;
        r_cls3       <= n_cls3;
        r_disc       <= n_disc;
    end

    assign o_push = r_v3;
    assign o_ma   = r_ma3;
    assign o_mb   = r_mb3;
    assign o_mc   = r_mc3;
    assign o_disc = r_disc;
    assign o_cls  = r_cls3;

    `QRS_ASSERT(a_accept_enters, w_accept |=> r_v1, "accepted item did not enter pipeline")

endmodule

`default_nettype wire

// ----- src/qrs_fifo.sv -----
// short queue that decouples the front end from the back end
`default_nettype none
`include "assert_macros.svh"

module qrs_fifo
    import qrs_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    output logic [QCW-1:0]        o_level
);

    logic [WIDTH-1:0] r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr, r_rd;
    logic [QCW-1:0]   r_count;
    logic             w_pop;

    assign o_valid = r_count != '0;
    assign w_pop   = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];
    assign o_level = r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + QCW'(i_push) - QCW'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `QRS_NEVER(a_no_overflow, i_push && !w_pop && r_count == QCW'(QDEPTH), "queue overflow")

endmodule

`default_nettype wire

// ----- src/qrs_back.sv -----
// back end: pipelined square root, two pipelined dividers, clamp and ordering
`default_nettype none
`include "assert_macros.svh"

module qrs_back
    import qrs_pkg::*;
#(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [W-1:0]      i_ma,
    input  wire logic [W-1:0]      i_mb,
    input  wire logic [W-1:0]      i_mc,
    input  wire logic [2*W+1:0]    i_disc,
    input  wire t_cls              i_cls,
    output logic                   o_valid,
    output logic signed [W-1:0]    o_root_low,
    output logic signed [W-1:0]    o_root_high,
    output logic [1:0]             o_status,
    output logic                   o_saturated
);

    localparam int SW  = W + 1;
    localparam int DW  = 2 * W + 2;
    localparam int RW  = SW + 2;
    localparam int DVW = W + 2;
    localparam int NW  = W + 2 + F;
    localparam logic [NW-1:0] LIM_N = NW'(1) << (W - 1);
    localparam logic [NW-1:0] LIM_P = LIM_N - 1'b1;

    // square root stages
    logic            r_sv   [SW+1];
    logic [RW-1:0]   r_srem [SW+1];
    logic [SW-1:0]   r_sroot[SW+1];
    logic [DW-1:0]   r_sd   [SW+1];
    logic [W-1:0]    r_sma  [SW+1];
    logic [W-1:0]    r_smb  [SW+1];
    logic [W-1:0]    r_smc  [SW+1];
    logic            r_sdz  [SW+1];
    t_cls            r_scls [SW+1];

    // divider stages
    logic            r_dv   [NW+1];
    logic [NW-1:0]   r_z0   [NW+1];
    logic [NW-1:0]   r_z1   [NW+1];
    logic [DVW-1:0]  r_r0   [NW+1];
    logic [DVW-1:0]  r_r1   [NW+1];
    logic [DVW-1:0]  r_d0   [NW+1];
    logic [DVW-1:0]  r_d1   [NW+1];
    logic            r_ddz  [NW+1];
    t_cls            r_dcls [NW+1];

    logic [DVW-1:0]  w_q2;

    // clamp stage
    logic               r_cv;
    logic signed [W-1:0] r_cx0, r_cx1;
    logic               r_csat;
    t_cls               r_ccls;

    logic               w_neg0, w_neg1, w_sat0, w_sat1;
    logic [NW-1:0]      w_lim0, w_lim1;
    logic [W-1:0]       w_mag0, w_mag1, w_val0, w_val1;

    // square root stage zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else begin
            r_sv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_srem[0]  <= '0;
        r_sroot[0] <= '0;
        r_sd[0]    <= i_disc;
        r_sma[0]   <= i_ma;
        r_smb[0]   <= i_mb;
        r_smc[0]   <= i_mc;
        r_sdz[0]   <= i_disc == '0;
        r_scls[0]  <= i_cls;
    end

    // one root bit per stage
    for (genvar s = 0; s < SW; s++) begin : g_sqrt
        logic [RW-1:0] w_rsh, w_trial;
        logic          w_ge;

        assign w_rsh   = {r_srem[s][RW-3:0], r_sd[s][DW-1 -: 2]};
        assign w_trial = {r_sroot[s], 2'b01};
        assign w_ge    = w_rsh >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s+1] <= 1'b0;
            end else begin
                r_sv[s+1] <= r_sv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_srem[s+1]  <= w_ge ? (w_rsh - w_trial) : w_rsh;
            r_sroot[s+1] <= {r_sroot[s][SW-2:0], w_ge};
            r_sd[s+1]    <= {r_sd[s][DW-3:0], 2'b00};
            r_sma[s+1]   <= r_sma[s];
            r_smb[s+1]   <= r_smb[s];
            r_smc[s+1]   <= r_smc[s];
            r_sdz[s+1]   <= r_sdz[s];
            r_scls[s+1]  <= r_scls[s];
        end
    end

    // q2 = |b| + sqrt(d), loads both dividers
    assign w_q2 = {2'b00, r_smb[SW]} + {1'b0, r_sroot[SW]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_sv[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_z0[0]   <= {w_q2, {F{1'b0}}};
        r_d0[0]   <= {1'b0, r_sma[SW], 1'b0};
        r_z1[0]   <= {1'b0, r_smc[SW], 1'b0, {F{1'b0}}};
        r_d1[0]   <= w_q2;
        r_r0[0]   <= '0;
        r_r1[0]   <= '0;
        r_ddz[0]  <= r_sdz[SW];
        r_dcls[0] <= r_scls[SW];
    end

    // one quotient bit per stage in each divider
    for (genvar n = 0; n < NW; n++) begin : g_div
        logic [DVW:0] w_sh0, w_sh1, w_sub0, w_sub1;
        logic         w_ge0, w_ge1;

        assign w_sh0  = {r_r0[n], r_z0[n][NW-1]};
        assign w_sh1  = {r_r1[n], r_z1[n][NW-1]};
        assign w_ge0  = w_sh0 >= {1'b0, r_d0[n]};
        assign w_ge1  = w_sh1 >= {1'b0, r_d1[n]};
        assign w_sub0 = w_ge0 ? (w_sh0 - {1'b0, r_d0[n]}) : w_sh0;
        assign w_sub1 = w_ge1 ? (w_sh1 - {1'b0, r_d1[n]}) : w_sh1;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[n+1] <= 1'b0;
            end else begin
                r_dv[n+1] <= r_dv[n];
            end
        end

        always_ff @(posedge i_clk) begin
            r_r0[n+1]   <= w_sub0[DVW-1:0];
            r_r1[n+1]   <= w_sub1[DVW-1:0];
            r_z0[n+1]   <= {r_z0[n][NW-2:0], w_ge0};
            r_z1[n+1]   <= {r_z1[n][NW-2:0], w_ge1};
            r_d0[n+1]   <= r_d0[n];
            r_d1[n+1]   <= r_d1[n];
            r_ddz[n+1]  <= r_ddz[n];
            r_dcls[n+1] <= r_dcls[n];
        end
    end

    // clamp magnitudes and apply signs
    assign w_neg0 = r_dcls[NW].b_pos != r_dcls[NW].a_neg;
    assign w_neg1 = r_dcls[NW].b_pos != r_dcls[NW].c_neg;
    assign w_lim0 = w_neg0 ? LIM_N : LIM_P;
    assign w_lim1 = w_neg1 ? LIM_N : LIM_P;
    assign w_sat0 = r_z0[NW] > w_lim0;
    assign w_sat1 = r_z1[NW] > w_lim1;
    assign w_mag0 = w_sat0 ? w_lim0[W-1:0] : r_z0[NW][W-1:0];
    assign w_mag1 = w_sat1 ? w_lim1[W-1:0] : r_z1[NW][W-1:0];
    assign w_val0 = w_neg0 ? (~w_mag0 + 1'b1) : w_mag0;
    assign w_val1 = w_neg1 ? (~w_mag1 + 1'b1) : w_mag1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else begin
            r_cv <= r_dv[NW];
        end
    end

    // a double root repeats the first quotient
    always_ff @(posedge i_clk) begin
        r_cx0  <= w_val0;
        r_cx1  <= r_ddz[NW] ? w_val0 : w_val1;
        r_csat <= w_sat0 || (!r_ddz[NW] && w_sat1);
        r_ccls <= r_dcls[NW];
    end

    // ordering and status, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        o_status <= r_ccls.status;
        if (r_ccls.status != ST_OK) begin
            o_root_low  <= '0;
            o_root_high <= '0;
            o_saturated <= 1'b0;
        end else begin
            o_saturated <= r_csat;
            if (r_cx0 > r_cx1) begin
                o_root_low  <= r_cx1;
                o_root_high <= r_cx0;
            end else begin
                o_root_low  <= r_cx0;
                o_root_high <= r_cx1;
            end
        end
    end

    `QRS_ASSERT(a_sorted, o_valid |-> (o_root_low <= o_root_high), "roots out of order")
    `QRS_ASSERT(a_fail_zero, (o_valid && o_status != ST_OK) |-> (o_root_low == '0 && o_root_high == '0 && !o_saturated), "failed item carries roots")

endmodule

`default_nettype wire

// ----- src/quadratic_real_root_solver.sv -----
// throughput: one item per cycle while busy is low; the square root takes DATA_WIDTH+1 stages and each
//   divider DATA_WIDTH+FRAC_BITS+2 stages, one result bit per stage
// busy stays low in steady flow; it rises only if the front-to-back queue could fill
// results come out one cycle wide on o_valid and are not held for the receiver
// reset (synchronous, active low) empties the queue and clears every pipeline valid bit
`default_nettype none

module quadratic_real_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [DATA_WIDTH-1:0]  i_coef_a,
    input  wire logic signed [DATA_WIDTH-1:0]  i_coef_b,
    input  wire logic signed [DATA_WIDTH-1:0]  i_coef_c,
    output logic                               o_valid,
    output logic signed [DATA_WIDTH-1:0]       o_root_low,
    output logic signed [DATA_WIDTH-1:0]       o_root_high,
    output logic [1:0]                         o_status,
    output logic                               o_saturated
);

    localparam int W  = DATA_WIDTH;
    localparam int DW = 2 * W + 2;
    localparam int CW = $bits(t_cls);
    localparam int PW = 3 * W + DW + CW;

    logic            w_push, w_qvalid;
    logic [QCW-1:0]  w_level;
    logic [W-1:0]    w_ma, w_mb, w_mc;
    logic [DW-1:0]   w_disc;
    t_cls            w_cls, w_qcls;
    logic [PW-1:0]   w_qin, w_qout;

    // front end
    qrs_front #(.W(W)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_coef_a (i_coef_a),
        .i_coef_b (i_coef_b),
        .i_coef_c (i_coef_c),
        .i_level  (w_level),
        .o_push   (w_push),
        .o_ma     (w_ma),
        .o_mb     (w_mb),
        .o_mc     (w_mc),
        .o_disc   (w_disc),
        .o_cls    (w_cls)
    );

    // queue, drained whenever it holds an item
    assign w_qin  = {w_cls, w_ma, w_mb, w_mc, w_disc};
    assign w_qcls = t_cls'(w_qout[PW-1 -: CW]);

    qrs_fifo #(.WIDTH(PW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_qin),
        .i_pop   (w_qvalid),
        .o_valid (w_qvalid),
        .o_data  (w_qout),
        .o_level (w_level)
    );

    // back end
    qrs_back #(.W(W), .F(FRAC_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_qvalid),
        .i_ma        (w_qout[DW+3*W-1 -: W]),
        .i_mb        (w_qout[DW+2*W-1 -: W]),
        .i_mc        (w_qout[DW+W-1 -: W]),
        .i_disc      (w_qout[DW-1:0]),
        .i_cls       (w_qcls),
        .o_valid     (o_valid),
        .o_root_low  (o_root_low),
        .o_root_high (o_root_high),
        .o_status    (o_status),
        .o_saturated (o_saturated)
    );

endmodule

`default_nettype wire

// ----- verif/quadratic_real_root_solver_test.sv -----
// self-checking testbench for the quadratic real root solver
`timescale 1ns / 100ps
`default_nettype none

module quadratic_real_root_solver_test;
    import qrs_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int LATENCY    = 2 * DATA_WIDTH + FRAC_BITS + 11;
    localparam int MAX_CYCLES = 400000;
    localparam int CALM_ITEMS = 300;

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    typedef struct {
        t_word a;
        t_word b;
        t_word c;
    } t_coefs;

    typedef struct {
        t_word   lo;
        t_word   hi;
        t_status status;
        logic    sat;
    } t_roots;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    t_word i_coef_a = '0;
    t_word i_coef_b = '0;
    t_word i_coef_c = '0;
    logic  busy;
    logic  o_valid;
    t_word o_root_low;
    t_word o_root_high;
    logic [1:0] o_status;
    logic  o_saturated;

    t_coefs pending_items[$];
    t_roots expected_roots[$];
    int     errors = 0;
    int     cycles = 0;
    int     idle_left = 0;
    logic   took = 1'b0;

    quadratic_real_root_solver #(
        .FRAC_BITS (FRAC_BITS),
        .DATA_WIDTH(DATA_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_coef_a   (i_coef_a),
        .i_coef_b   (i_coef_b),
        .i_coef_c   (i_coef_c),
        .o_valid    (o_valid),
        .o_root_low (o_root_low),
        .o_root_high(o_root_high),
        .o_status   (o_status),
        .o_saturated(o_saturated)
    );

    always #5 i_clk = ~i_clk;

    // floor square root of a wide value
    function automatic logic [127:0] isqrt(input logic [127:0] d);
        logic [127:0] res;
        logic [127:0] t;
        res = '0;
        for (int i = 63; i >= 0; i--) begin
            t = res | (128'd1 << i);
            if (t * t <= d) res = t;
        end
        return res;
    endfunction

    // clamp a magnitude to the word range and apply the sign
    function automatic longint clamp_root(input logic [127:0] mag, input logic neg,
                                          inout logic sat);
        logic [127:0] limit;
        limit = neg ? (128'd1 << (DATA_WIDTH - 1)) : (128'd1 << (DATA_WIDTH - 1)) - 1;
        if (mag > limit) begin
            mag = limit;
            sat = 1'b1;
        end
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    // roots of a*x^2 + b*x + c, exact integer discriminant, stable form
    function automatic t_roots solve_quadratic(input t_coefs k);
        t_roots r;
        longint sa, sb, sc, r0, r1, tmp;
        logic [127:0] ma, mb, mc, bb, ac4, disc, q2;
        logic bpos, sat;
        sa = k.a; sb = k.b; sc = k.c;
        ma = sa < 0 ? -sa : sa;
        mb = sb < 0 ? -sb : sb;
        mc = sc < 0 ? -sc : sc;
        r0 = 0; r1 = 0; sat = 1'b0;
        r.status = ST_OK;
        if (sa == 0) begin
            r.status = ST_AZERO;
        end else begin
            bb = mb * mb;
            ac4 = (ma * mc) << 2;
            if ((sa < 0) != (sc < 0) && sc != 0) begin
                disc = bb + ac4;
            end else if (bb < ac4) begin
                r.status = ST_NOROOT;
            end else begin
                disc = bb - ac4;
            end
            if (r.status == ST_OK) begin
                bpos = sb > 0;
                if (disc == 0) begin
                    r0 = clamp_root((mb << FRAC_BITS) / (ma << 1), bpos != (sa < 0), sat);
                    r1 = r0;
                end else begin
                    q2 = mb + isqrt(disc);
                    r0 = clamp_root((q2 << FRAC_BITS) / (ma << 1), bpos != (sa < 0), sat);
                    r1 = clamp_root(((mc << 1) << FRAC_BITS) / q2, bpos != (sc < 0), sat);
                end
                if (r0 > r1) begin
                    tmp = r0; r0 = r1; r1 = tmp;
                end
            end
        end
        r.lo = t_word'(r0);
        r.hi = t_word'(r1);
        r.sat = sat;
        return r;
    endfunction

    function automatic t_word rand_word();
        return t_word'($urandom);
    endfunction

    // small integer coefficient in Q16.16, optionally with a random fraction
    function automatic t_word rand_small(input int span);
        t_word w;
        w = t_word'($urandom_range(0, 2 * span) - span) <<< FRAC_BITS;
        if ($urandom_range(0, 1)) w = w + t_word'($urandom_range(0, 65535));
        return w;
    endfunction

    task automatic add_item(input t_word a, input t_word b, input t_word c);
        t_coefs k;
        k.a = a; k.b = b; k.c = c;
        pending_items = {pending_items, k};
    endtask

    // accept items and check results at the rising edge
    always @(posedge i_clk) begin
        t_roots want;
        logic   took_now;
        took_now = 1'b0;
        cycles <= cycles + 1;
        if (i_rst_n && start && !busy) begin
            t_coefs k;
            k.a = i_coef_a; k.b = i_coef_b; k.c = i_coef_c;
            expected_roots = {expected_roots, solve_quadratic(k)};
            void'(pending_items.pop_front());
            took_now = 1'b1;
        end
        took <= took_now;
        if (i_rst_n && o_valid) begin
            if (expected_roots.size() == 0) begin
                $display("%0t: result with no item outstanding: %h %h %0d %b", $time,
                         o_root_low, o_root_high, o_status, o_saturated);
                errors++;
            end else begin
                want = expected_roots.pop_front();
                if (o_root_low !== want.lo) begin
                    $display("%0t: root_low expected %h actual %h", $time, want.lo, o_root_low);
                    errors++;
                end
                if (o_root_high !== want.hi) begin
                    $display("%0t: root_high expected %h actual %h", $time, want.hi,
                             o_root_high);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             o_status);
                    errors++;
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, want.sat,
                             o_saturated);
                    errors++;
                end
            end
        end
    end

    // drive the next item at the falling edge, with random idle bursts
    always @(negedge i_clk) begin
        if (!i_rst_n || (start && !took)) begin
            // hold the current item until it is taken
        end else if (idle_left > 0) begin
            start <= 1'b0;
            idle_left <= idle_left - 1;
        end else if (pending_items.size() > 0) begin
            start <= 1'b1;
            i_coef_a <= pending_items[0].a;
            i_coef_b <= pending_items[0].b;
            i_coef_c <= pending_items[0].c;
            if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 7) == 0)
                idle_left <= $urandom_range(1, 16);
        end else begin
            start <= 1'b0;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycles > MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int k;
        t_word one;
        one = t_word'(1) <<< FRAC_BITS;

        // directed: a zero, no roots, double root, extremes, saturation
        add_item('0, one, one);
        add_item('0, '0, '0);
        add_item(one, '0, one);
        add_item(one, 2 * one, one);
        add_item(one, -2 * one, one);
        add_item(one, -3 * one, 2 * one);
        add_item(-one, one, 2 * one);
        add_item(one, '0, -4 * one);
        add_item(one, 5 * one, '0);
        add_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        add_item(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        add_item(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
        add_item(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        add_item(32'sh0000_0001, 32'sh7fff_ffff, 32'sh0000_0001);
        add_item(32'sh0000_0001, 32'sh8000_0000, 32'sh8000_0000);
        add_item(32'sh0000_0001, '0, 32'sh8000_0000);
        add_item(32'sh0000_0001, 32'sh0000_0002, 32'sh0000_0001);
        add_item(32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff);
        add_item(32'shffff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
        add_item(-one, '0, '0);

        // random: full range, small coefficients, built from integer roots, and small a with full-range b and c
        for (k = 0; k < 1500; k++) begin
            case ($urandom_range(0, 3))
                0: add_item(rand_word(), rand_word(), rand_word());
                1: add_item(rand_small(8), rand_small(64), rand_small(64));
                2: begin
                    int ka, ra, rb;
                    ka = $urandom_range(1, 6) * ($urandom_range(0, 1) ? 1 : -1);
                    ra = $urandom_range(0, 40) - 20;
                    rb = $urandom_range(0, 1) ? ra : $urandom_range(0, 40) - 20;
                    add_item(t_word'(ka) <<< FRAC_BITS, t_word'(-ka * (ra + rb)) <<< FRAC_BITS,
                             t_word'(ka * ra * rb) <<< FRAC_BITS);
                end
                default: add_item($urandom_range(0, 15) == 0 ? '0 : t_word'($urandom_range(1, 255)),
                                  rand_word(), rand_word());
            endcase
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !start);
        wait (expected_roots.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);

        if (errors == 0 && expected_roots.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
